@@ rtl/u8f_pkg.sv @@
// Shared types, constants and helper functions for the 8N1 UART with FIFOs.
package u8f_pkg;

  localparam int FIFO_DEPTH  = 16;
  localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W       = PTR_W + 1;
  localparam int LEVEL_W     = 4;
  localparam int TICKS_W     = 12;
  localparam int RX_TICKS_W  = TICKS_W + 1;
  localparam int BITS_W      = 4;
  localparam int BYTE_W      = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int REG_IDX_W   = ADDR_W - 2;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [TICKS_W-1:0]    ticks_t;
  typedef logic [RX_TICKS_W-1:0] rx_ticks_t;
  typedef logic [BITS_W-1:0]     bits_t;
  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;

  localparam reg_idx_t REG_BIT_TICKS   = reg_idx_t'(0);
  localparam ticks_t   BIT_TICKS_RESET = ticks_t'(52);
  localparam ticks_t   BIT_TICKS_MIN   = ticks_t'(4);
  localparam bits_t    FRAME_BITS      = bits_t'(10);
  localparam bits_t    DATA_BITS       = bits_t'(8);
  localparam cnt_t     FULL_COUNT      = cnt_t'(FIFO_DEPTH - 1);

  typedef struct packed {
    logic  rx_line;
    logic  write_request;
    byte_t write_byte;
    logic  read_request;
  } tick_t;

  function automatic ptr_t next_ptr(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic cnt_t fifo_count(ptr_t w, ptr_t r);
    cnt_t c;
    if (w >= r) begin
      c = cnt_t'(w) - cnt_t'(r);
    end else begin
      c = cnt_t'(w) + cnt_t'(FIFO_DEPTH) - cnt_t'(r);
    end
    return c;
  endfunction

endpackage

@@ rtl/u8f_if.sv @@
// Stream interfaces for the tick channel and the result channel.
interface u8f_tick_if;
  logic       valid;
  logic       ready;
  logic       rx_line;
  logic       write_request;
  logic [7:0] write_byte;
  logic       read_request;

  modport source (output valid, output rx_line, output write_request, output write_byte,
                  output read_request, input ready);
  modport sink (input valid, input rx_line, input write_request, input write_byte,
                input read_request, output ready);
endinterface

interface u8f_result_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       write_refused;
  logic [7:0] read_data;
  logic       read_valid;
  logic [3:0] rx_level;
  logic [3:0] tx_level;

  modport source (output valid, output tx_line, output write_refused, output read_data,
                  output read_valid, output rx_level, output tx_level, input ready);
  modport sink (input valid, input tx_line, input write_refused, input read_data,
                input read_valid, input rx_level, input tx_level, output ready);
endinterface

@@ rtl/uart_8n1_with_fifos.sv @@
// Top level of the timer-driven 8N1 UART with transmit and receive FIFOs.
//
// Each word on the tick channel is one timer tick: the sampled rx_line level,
// an optional write of write_byte into the transmit FIFO and an optional read
// from the receive FIFO. Each tick gives exactly one word on the result
// channel: tx_line after the tick, write_refused, read_data/read_valid and the
// two FIFO levels. The FIFOs hold up to 15 bytes each.
//
// Throughput: one tick per cycle, sustained, while the result side does not
// stall. Each accepted tick passes through the two-entry tick queue and then
// the result register around the per-tick engine.
// When the result side stalls, the result register holds its word and the
// tick queue takes up to two more ticks before tick.ready drops.
// bit_ticks is written through the APB port at address 0 (reset value 52,
// values below 4 act as 4). Reset empties both FIFOs, drives tx_line high
// and returns the receiver to waiting for a falling edge.
module uart_8n1_with_fifos (
  input  logic                       clk,
  input  logic                       rst,
  u8f_tick_if.sink                   tick,
  u8f_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [u8f_pkg::ADDR_W-1:0] paddr,
  input  logic [u8f_pkg::DATA_W-1:0] pwdata,
  output logic [u8f_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import u8f_pkg::*;

  ticks_t bit_ticks;
  logic   q_valid;
  tick_t  q_word;
  logic   q_take;

  u8f_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .bit_ticks (bit_ticks)
  );

  u8f_front u_front (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_take  (q_take)
  );

  u8f_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .bit_ticks (bit_ticks),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_take    (q_take),
    .result    (result)
  );

  a_full_queue_has_word: assert property (@(posedge clk) disable iff (rst)
    !tick.ready |-> q_valid)
    else $error("tick queue full while back part sees no word");

  a_idle_read_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.read_valid) |-> (result.read_data == '0))
    else $error("read_data nonzero without a popped byte");

  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    q_take |-> (q_valid && (!result.valid || result.ready)))
    else $error("back part advanced without a word or without result room");

  a_reset_clears_result: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

endmodule

@@ rtl/u8f_regs.sv @@
// APB-style configuration register holding bit_ticks.
module u8f_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [u8f_pkg::ADDR_W-1:0] paddr,
  input  logic [u8f_pkg::DATA_W-1:0] pwdata,
  output logic [u8f_pkg::DATA_W-1:0] prdata,
  output logic                   pready,
  output u8f_pkg::ticks_t        bit_ticks
);
  import u8f_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (idx == REG_BIT_TICKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= BIT_TICKS_RESET;
    end else if (wr_en) begin
      bit_ticks <= pwdata[TICKS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == REG_BIT_TICKS) begin
      prdata = DATA_W'(bit_ticks);
    end
  end

endmodule

@@ rtl/u8f_front.sv @@
// Front part: accepts tick words and holds them in a short queue for the back part.
module u8f_front (
  input  logic              clk,
  input  logic              rst,
  u8f_tick_if.sink          tick,
  output logic              q_valid,
  output u8f_pkg::tick_t    q_word,
  input  logic              q_take
);
  import u8f_pkg::*;

  tick_t                slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    count;
  logic                 push;
  logic                 pop;

  assign tick.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push       = tick.valid && tick.ready;
  assign q_valid    = (count != '0);
  assign pop        = q_valid && q_take;
  assign q_word     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{rx_line:       tick.rx_line,
                        write_request: tick.write_request,
                        write_byte:    tick.write_byte,
                        read_request:  tick.read_request};
    end
  end

endmodule

@@ rtl/u8f_engine.sv @@
// Back part: FIFOs, TX and RX, result register; one tick a cycle unless stalled.
module u8f_engine (
  input  logic              clk,
  input  logic              rst,
  input  u8f_pkg::ticks_t   bit_ticks,
  input  logic              q_valid,
  input  u8f_pkg::tick_t    q_word,
  output logic              q_take,
  u8f_result_if.source      result
);
  import u8f_pkg::*;

  byte_t     tx_mem [FIFO_DEPTH];
  byte_t     rx_mem [FIFO_DEPTH];

  ptr_t      tx_wr, tx_rd, rx_wr, rx_rd;
  logic [8:0] tx_frame;
  bits_t     tx_bits_left;
  ticks_t    tx_tick_count;
  logic      tx_line;
  byte_t     rx_shift;
  bits_t     rx_bits_left;
  rx_ticks_t rx_tick_count;
  logic      rx_prev;

  ptr_t      tx_wr_next, tx_rd_next, rx_wr_next, rx_rd_next;
  logic [8:0] tx_frame_next;
  bits_t     tx_bits_left_next;
  ticks_t    tx_tick_count_next;
  logic      tx_line_next;
  byte_t     rx_shift_next;
  bits_t     rx_bits_left_next;
  rx_ticks_t rx_tick_count_next;
  logic      push, rx_store_en;
  logic      refused, pop;
  byte_t     read_byte;
  ticks_t    bt;
  byte_t     load_byte;
  logic      adv;

  assign adv    = q_valid && (!result.valid || result.ready);
  assign q_take = adv;
  assign bt     = (bit_ticks < BIT_TICKS_MIN) ? BIT_TICKS_MIN : bit_ticks;

  always_comb begin
    pop        = q_word.read_request && (rx_rd != rx_wr);
    read_byte  = pop ? rx_mem[rx_rd] : '0;
    rx_rd_next = pop ? next_ptr(rx_rd) : rx_rd;

    refused    = q_word.write_request && (fifo_count(tx_wr, tx_rd) >= FULL_COUNT);
    push       = q_word.write_request && !refused;
    tx_wr_next = push ? next_ptr(tx_wr) : tx_wr;

    tx_frame_next      = tx_frame;
    tx_bits_left_next  = tx_bits_left;
    tx_tick_count_next = tx_tick_count;
    tx_line_next       = tx_line;
    tx_rd_next         = tx_rd;
    load_byte          = (tx_rd == tx_wr) ? q_word.write_byte : tx_mem[tx_rd];
    if (tx_bits_left_next != '0) begin
      if (tx_tick_count_next != '0) begin
        tx_tick_count_next = tx_tick_count_next - ticks_t'(1);
      end
      if (tx_tick_count_next == '0) begin
        tx_bits_left_next = tx_bits_left_next - bits_t'(1);
        if (tx_bits_left_next != '0) begin
          tx_line_next       = tx_frame_next[0];
          tx_frame_next      = {1'b0, tx_frame_next[8:1]};
          tx_tick_count_next = bt;
        end else begin
          tx_line_next = 1'b1;
        end
      end
    end
    if (tx_bits_left_next == '0 && tx_rd != tx_wr_next) begin
      tx_rd_next         = next_ptr(tx_rd);
      tx_frame_next      = {1'b1, load_byte};
      tx_bits_left_next  = FRAME_BITS;
      tx_line_next       = 1'b0;
      tx_tick_count_next = bt;
    end

    rx_shift_next      = rx_shift;
    rx_bits_left_next  = rx_bits_left;
    rx_tick_count_next = rx_tick_count;
    rx_wr_next         = rx_wr;
    rx_store_en        = 1'b0;
    if (rx_bits_left == '0) begin
      if (rx_prev && !q_word.rx_line) begin
        rx_bits_left_next  = DATA_BITS;
        rx_tick_count_next = rx_ticks_t'(bt) + rx_ticks_t'(bt >> 1);
      end
    end else begin
      if (rx_tick_count_next != '0) begin
        rx_tick_count_next = rx_tick_count_next - rx_ticks_t'(1);
      end
      if (rx_tick_count_next == '0) begin
        rx_shift_next      = {q_word.rx_line, rx_shift[7:1]};
        rx_bits_left_next  = rx_bits_left - bits_t'(1);
        rx_tick_count_next = rx_ticks_t'(bt);
        if (rx_bits_left_next == '0) begin
          rx_tick_count_next = '0;
          if (fifo_count(rx_wr, rx_rd_next) < FULL_COUNT) begin
            rx_store_en = 1'b1;
            rx_wr_next  = next_ptr(rx_wr);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_wr         <= '0;
      tx_rd         <= '0;
      rx_wr         <= '0;
      rx_rd         <= '0;
      tx_frame      <= '0;
      tx_bits_left  <= '0;
      tx_tick_count <= '0;
      tx_line       <= 1'b1;
      rx_shift      <= '0;
      rx_bits_left  <= '0;
      rx_tick_count <= '0;
      rx_prev       <= 1'b1;
      result.valid  <= 1'b0;
    end else begin
      if (adv) begin
        tx_wr         <= tx_wr_next;
        tx_rd         <= tx_rd_next;
        rx_wr         <= rx_wr_next;
        rx_rd         <= rx_rd_next;
        tx_frame      <= tx_frame_next;
        tx_bits_left  <= tx_bits_left_next;
        tx_tick_count <= tx_tick_count_next;
        tx_line       <= tx_line_next;
        rx_shift      <= rx_shift_next;
        rx_bits_left  <= rx_bits_left_next;
        rx_tick_count <= rx_tick_count_next;
        rx_prev       <= q_word.rx_line;
        result.valid  <= 1'b1;
      end else if (result.ready) begin
        result.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && push) begin
      tx_mem[tx_wr] <= q_word.write_byte;
    end
    if (adv && rx_store_en) begin
      rx_mem[rx_wr] <= rx_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.tx_line       <= tx_line_next;
      result.write_refused <= refused;
      result.read_data     <= read_byte;
      result.read_valid    <= pop;
      result.rx_level      <= LEVEL_W'(fifo_count(rx_wr_next, rx_rd_next));
      result.tx_level      <= LEVEL_W'(fifo_count(tx_wr_next, tx_rd_next));
    end
  end

endmodule

@@ sim/tb_uart_8n1_with_fifos.sv @@
// Self-checking testbench for the timer-driven 8N1 UART with transmit and receive FIFOs.
`timescale 1ns / 1ps

module tb_uart_8n1_with_fifos;
  import u8f_pkg::*;

  typedef struct packed {
    logic   tx_line;
    logic   write_refused;
    byte_t  read_data;
    logic   read_valid;
    level_t rx_level;
    level_t tx_level;
  } uart_result_t;

  typedef struct {
    logic lvl;
    int   len;
  } line_span_t;

  class uart_scoreboard;
    ticks_t       bit_ticks;
    byte_t        tx_mem[FIFO_DEPTH];
    byte_t        rx_mem[FIFO_DEPTH];
    ptr_t         tx_wp, tx_rp, rx_wp, rx_rp;
    logic [9:0]   tx_frame;
    bits_t        tx_bits_left, rx_bits_left;
    ticks_t       tx_ticks;
    rx_ticks_t    rx_ticks;
    logic         tx_level_bit, rx_prev;
    byte_t        rx_shift;
    uart_result_t due_results[$];
    int           errors;
    int           checked;

    function new();
      bit_ticks    = BIT_TICKS_RESET;
      tx_wp        = '0;
      tx_rp        = '0;
      rx_wp        = '0;
      rx_rp        = '0;
      tx_frame     = '0;
      tx_bits_left = '0;
      rx_bits_left = '0;
      tx_ticks     = '0;
      rx_ticks     = '0;
      tx_level_bit = 1'b1;
      rx_prev      = 1'b1;
      rx_shift     = '0;
      errors       = 0;
      checked      = 0;
    endfunction

    function void step_uart(tick_t t);
      uart_result_t r;
      ticks_t       bt;
      r  = '0;
      bt = (bit_ticks < BIT_TICKS_MIN) ? BIT_TICKS_MIN : bit_ticks;

      if (t.read_request && rx_rp != rx_wp) begin
        r.read_data  = rx_mem[rx_rp];
        r.read_valid = 1'b1;
        rx_rp        = next_ptr(rx_rp);
      end

      if (t.write_request) begin
        if (fifo_count(tx_wp, tx_rp) >= FULL_COUNT) begin
          r.write_refused = 1'b1;
        end else begin
          tx_mem[tx_wp] = t.write_byte;
          tx_wp         = next_ptr(tx_wp);
        end
      end

      if (tx_bits_left != 0) begin
        if (tx_ticks != 0) tx_ticks = tx_ticks - ticks_t'(1);
        if (tx_ticks == 0) begin
          tx_bits_left = tx_bits_left - bits_t'(1);
          if (tx_bits_left != 0) begin
            tx_level_bit = tx_frame[0];
            tx_frame     = tx_frame >> 1;
            tx_ticks     = bt;
          end else begin
            tx_level_bit = 1'b1;
          end
        end
      end
      if (tx_bits_left == 0 && tx_rp != tx_wp) begin
        tx_frame     = {1'b1, tx_mem[tx_rp], 1'b0};
        tx_rp        = next_ptr(tx_rp);
        tx_bits_left = FRAME_BITS;
        tx_level_bit = tx_frame[0];
        tx_frame     = tx_frame >> 1;
        tx_ticks     = bt;
      end

      if (rx_bits_left == 0) begin
        if (rx_prev && !t.rx_line) begin
          rx_bits_left = DATA_BITS;
          rx_ticks     = rx_ticks_t'(bt) + rx_ticks_t'(bt >> 1);
        end
      end else begin
        if (rx_ticks != 0) rx_ticks = rx_ticks - rx_ticks_t'(1);
        if (rx_ticks == 0) begin
          rx_shift     = {t.rx_line, rx_shift[7:1]};
          rx_bits_left = rx_bits_left - bits_t'(1);
          rx_ticks     = rx_ticks_t'(bt);
          if (rx_bits_left == 0) begin
            rx_ticks = '0;
            if (fifo_count(rx_wp, rx_rp) < FULL_COUNT) begin
              rx_mem[rx_wp] = rx_shift;
              rx_wp         = next_ptr(rx_wp);
            end
          end
        end
      end

      rx_prev    = t.rx_line;
      r.tx_line  = tx_level_bit;
      r.rx_level = level_t'(fifo_count(rx_wp, rx_rp));
      r.tx_level = level_t'(fifo_count(tx_wp, tx_rp));
      due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(uart_result_t act);
      uart_result_t exp_r;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result word %h arrived with nothing expected", $time, act);
        return;
      end
      exp_r = due_results.pop_front();
      checked++;
      check_field("tx_line", exp_r.tx_line, act.tx_line);
      check_field("write_refused", exp_r.write_refused, act.write_refused);
      check_field("read_data", exp_r.read_data, act.read_data);
      check_field("read_valid", exp_r.read_valid, act.read_valid);
      check_field("rx_level", exp_r.rx_level, act.rx_level);
      check_field("tx_level", exp_r.tx_level, act.tx_level);
    endfunction
  endclass

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int LONG_HOLD_AT = 150;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  u8f_tick_if   tick_ch();
  u8f_result_if result_ch();

  uart_scoreboard sb;
  bit             src_idle;
  bit             snk_idle;
  int             cycles = 0;
  int             hold_left;
  bit             long_hold_done;

  uart_8n1_with_fifos dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_result(uart_result_t'{result_ch.tx_line, result_ch.write_refused,
                                     result_ch.read_data, result_ch.read_valid,
                                     result_ch.rx_level, result_ch.tx_level});
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    hold_left       = 0;
    long_hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && sb.checked >= LONG_HOLD_AT) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && snk_idle && $urandom_range(0, 9) < 2) begin
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(logic rx, logic wr, byte_t wb, logic rd);
    int gap;
    gap = 0;
    if (src_idle && $urandom_range(0, 9) < 3) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.rx_line       <= rx;
    tick_ch.write_request <= wr;
    tick_ch.write_byte    <= wb;
    tick_ch.read_request  <= rd;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    sb.step_uart(tick_t'{rx, wr, wb, rd});
    @(negedge clk);
  endtask

  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_bit_ticks(logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BIT_TICKS, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.bit_ticks = ticks_t'(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic directed_ticks();
    byte_t corner[4];
    corner = '{8'h00, 8'hFF, 8'h01, 8'h80};
    send_tick(1'b1, 1'b0, 8'h00, 1'b1);
    send_tick(1'b1, 1'b0, 8'hFF, 1'b0);
    for (int i = 0; i < 18; i++) begin
      send_tick(i < 3, 1'b1, (i < 4) ? corner[i] : byte_t'($urandom), i[0]);
    end
    send_tick(1'b0, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic run_phase(logic [DATA_W-1:0] cfg, int n, int rd_pct, int wr_pct,
                           int noise_pct, int lead);
    line_span_t spans[$];
    line_span_t s;
    int         sent;
    int         bt;
    byte_t      b;
    drain_results();
    write_bit_ticks(cfg);
    src_idle = ($urandom_range(0, 3) != 0);
    snk_idle = ($urandom_range(0, 3) != 0);
    bt       = (sb.bit_ticks < BIT_TICKS_MIN) ? BIT_TICKS_MIN : sb.bit_ticks;
    sent     = 0;
    spans.push_back(line_span_t'{1'b1, lead});
    while (sent < n) begin
      if (spans.size() == 0) begin
        if ($urandom_range(0, 99) < noise_pct) begin
          repeat ($urandom_range(1, 6)) begin
            spans.push_back(line_span_t'{1'($urandom), $urandom_range(1, 2 * bt)});
          end
        end else begin
          b = $urandom;
          spans.push_back(line_span_t'{1'b0, bt});
          for (int i = 0; i < 8; i++) spans.push_back(line_span_t'{b[i], bt});
          spans.push_back(line_span_t'{1'b1, $urandom_range(1, 2 * bt)});
        end
      end
      s = spans.pop_front();
      for (int k = 0; k < s.len && sent < n; k++) begin
        send_tick(s.lvl, $urandom_range(0, 99) < wr_pct, byte_t'($urandom),
                  $urandom_range(0, 99) < rd_pct);
        sent++;
      end
    end
  endtask

  initial begin
    sb                    = new();
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.rx_line       = 1'b1;
    tick_ch.write_request = 1'b0;
    tick_ch.write_byte    = '0;
    tick_ch.read_request  = 1'b0;
    src_idle              = 1'b1;
    snk_idle              = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_ticks();
    run_phase(32'd4, 310, 0, 2, 0, 100);
    run_phase(32'd0, 110, 40, 4, 20, 8);
    run_phase(32'd3, 110, 5, 15, 20, 8);
    run_phase(32'h0001_2005, 110, 20, 3, 25, 8);
    run_phase(32'd9, 110, 15, 2, 15, 8);
    run_phase(32'd4095, 80, 25, 30, 10, 8);
    drain_results();

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/u8f_pkg.sv
rtl/u8f_if.sv
rtl/u8f_regs.sv
rtl/u8f_front.sv
rtl/u8f_engine.sv
rtl/uart_8n1_with_fifos.sv
sim/tb_uart_8n1_with_fifos.sv
